FILE: rtl/stereo_odom_timestamp_sync_assert.svh
// assertion macros for the stereo odometry timestamp sync block
// depends on clk_i and rst_ni being visible in the including module
`ifndef STEREO_ODOM_TIMESTAMP_SYNC_ASSERT_SVH
`define STEREO_ODOM_TIMESTAMP_SYNC_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SOTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SOTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/sots_pkg.sv
// shared types, constants and codes of the stereo odometry timestamp sync block
// no dependencies
`timescale 1ns / 1ps
package sots_pkg;

  localparam int unsigned TIME_W   = 48;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned ENTRY_W  = TIME_W + TAG_W;
  localparam int unsigned DELAY_W  = 21;
  localparam int unsigned TOL_W    = 24;
  localparam int unsigned IWC_W    = 5;
  localparam int unsigned OWC_W    = 6;
  localparam int unsigned ULIM_W   = 4;
  localparam int unsigned OFF_W    = 26;
  localparam int unsigned ALU_W    = TIME_W + 2;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 24;
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned N_W      = $clog2(MAX_RESULTS + 1);

  localparam int unsigned ODOM_DEPTH_DEF  = 32;
  localparam int unsigned IMAGE_DEPTH_DEF = 16;

  localparam logic [TOL_W-1:0]  TOL_RST  = 24'd3000000;
  localparam logic [IWC_W-1:0]  IWC_RST  = 5'd10;
  localparam logic [OWC_W-1:0]  OWC_RST  = 6'd15;
  localparam logic [ULIM_W-1:0] ULIM_RST = 4'd10;
  localparam logic [ULIM_W-1:0] UNSYNC_MAX = 4'd15;

  typedef enum logic [1:0] {
    FN_ADD_ODOM  = 2'd0,
    FN_ADD_LEFT  = 2'd1,
    FN_ADD_RIGHT = 2'd2,
    FN_SYNC      = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    SS_OK          = 3'd0,
    SS_NOT_STARTED = 3'd1,
    SS_EMPTY       = 3'd2,
    SS_GAP         = 3'd3,
    SS_WAIT        = 3'd4,
    SS_UNSYNC      = 3'd5
  } stat_e;

  typedef enum logic [1:0] {
    PH_NOT_STARTED = 2'd0,
    PH_STARTED     = 2'd1,
    PH_NORMAL      = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    CFG_IMAGE_DELAY  = 3'd0,
    CFG_GAP_TOL      = 3'd1,
    CFG_IMAGE_WAIT   = 3'd2,
    CFG_ODOM_WAIT    = 3'd3,
    CFG_UNSYNC_LIMIT = 3'd4
  } cfg_e;

  typedef enum logic [1:0] {
    OFF_NEG_D,
    OFF_D,
    OFF_TOL_MINUS_D,
    OFF_TOL_PLUS_D
  } off_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_CHK,
    ST_GAP1,
    ST_GAP2,
    ST_WAIT,
    ST_SCAN,
    ST_NEXT,
    ST_FIN,
    ST_STAT
  } state_e;

  // queue control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    logic rd_en;
    logic rd_back;
  } fifo_ctl_t;

  typedef struct packed {
    stat_e            stat;
    logic [TAG_W-1:0] ltag;
    logic [TAG_W-1:0] rtag;
    logic [TAG_W-1:0] otag;
    logic             ovld;
  } result_t;

endpackage

FILE: rtl/stereo_odom_timestamp_sync.sv
// stereo image / odometry timestamp synchronizer, top level with sequencer
// depends on sots_pkg, sots_fifo, sots_alu and stereo_odom_timestamp_sync_assert.svh
`timescale 1ns / 1ps
// Keeps three timestamped queues (odometry, left image, right image) and pairs
// images with the odometry words that precede them. Input words carry func in
// tuser; func 0..2 add a message, func 3 is a sync request. An add returns
// nothing. A sync request gives one or more result words, tlast on the final
// one: a status-only result, one word with image tags and no odometry if none
// is released, or one word per released odometry entry (at most 32). All time
// compares run one at a time through a single shared subtract/compare unit,
// each queue has one registered read port, and results wait while the output
// stalls. No new word is taken until the request is done; a finished result
// sits in the output register and does not block the next input. Configuration
// must be written through cfg_we_i / cfg_addr_i / cfg_wdata_i only while idle;
// the block does not enforce this. Indexes beyond the last register are ignored.
module stereo_odom_timestamp_sync import sots_pkg::*; #(
  parameter int unsigned ODOM_DEPTH  = ODOM_DEPTH_DEF,
  parameter int unsigned IMAGE_DEPTH = IMAGE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // time_us[47:0], msg_tag[63:48]
  input  logic [1:0]        s_axis_tuser,   // func[1:0]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [55:0]       m_axis_tdata,   // left_tag, right_tag, odom_tag, dropped, zero pad
  output logic [3:0]        m_axis_tuser,   // status[2:0], odom_valid[3]
  output logic              m_axis_tlast,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i
);

  localparam int unsigned OCW = $clog2(ODOM_DEPTH + 1);
  localparam int unsigned ICW = $clog2(IMAGE_DEPTH + 1);

  // configuration registers
  logic [DELAY_W-1:0] delay_q;
  logic [TOL_W-1:0]   tol_q;
  logic [IWC_W-1:0]   iwc_q;
  logic [OWC_W-1:0]   owc_q;
  logic [ULIM_W-1:0]  ulim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      tol_q   <= TOL_RST;
      iwc_q   <= IWC_RST;
      owc_q   <= OWC_RST;
      ulim_q  <= ULIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_addr_i))
        CFG_IMAGE_DELAY:  delay_q <= cfg_wdata_i[DELAY_W-1:0];
        CFG_GAP_TOL:      tol_q   <= cfg_wdata_i[TOL_W-1:0];
        CFG_IMAGE_WAIT:   iwc_q   <= cfg_wdata_i[IWC_W-1:0];
        CFG_ODOM_WAIT:    owc_q   <= cfg_wdata_i[OWC_W-1:0];
        CFG_UNSYNC_LIMIT: ulim_q  <= cfg_wdata_i[ULIM_W-1:0];
        default: ;
      endcase
    end
  end

  // state
  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [TIME_W-1:0] start_q, start_d;
  logic [ULIM_W-1:0] unsync_q, unsync_d;
  logic              drop_q, drop_d;
  logic              dr_q, dr_d;
  func_e             fn_q, fn_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [TAG_W-1:0]  ltag_q, ltag_d, rtag_q, rtag_d;
  logic [N_W-1:0]    n_q, n_d;
  stat_e             stat_q, stat_d;
  result_t           pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;
  result_t           out_q, out_d;
  logic              out_last_q, out_last_d, out_drop_q, out_drop_d;
  logic              out_vld_q, out_vld_d;

  // queues
  fifo_ctl_t          octl, lctl, rctl;
  logic [ENTRY_W-1:0] wr_entry, o_rd, l_rd, r_rd;
  logic [OCW-1:0]     o_cnt;
  logic [ICW-1:0]     l_cnt, r_cnt;
  logic               o_empty, l_empty, r_empty, o_full, l_full, r_full;

  assign wr_entry = {tag_q, time_q};

  sots_fifo #(.DEPTH(ODOM_DEPTH)) u_odom (
    .clk_i, .rst_ni, .ctl_i(octl), .data_i(wr_entry), .rd_data_o(o_rd),
    .count_o(o_cnt), .empty_o(o_empty), .full_o(o_full)
  );
  sots_fifo #(.DEPTH(IMAGE_DEPTH)) u_left (
    .clk_i, .rst_ni, .ctl_i(lctl), .data_i(wr_entry), .rd_data_o(l_rd),
    .count_o(l_cnt), .empty_o(l_empty), .full_o(l_full)
  );
  sots_fifo #(.DEPTH(IMAGE_DEPTH)) u_right (
    .clk_i, .rst_ni, .ctl_i(rctl), .data_i(wr_entry), .rd_data_o(r_rd),
    .count_o(r_cnt), .empty_o(r_empty), .full_o(r_full)
  );

  // shared compare unit
  logic [TIME_W-1:0] alu_a, alu_b;
  logic [OFF_W-1:0]  alu_off, d_ext, tol_ext;
  off_e              off_sel;
  logic              alu_neg;

  assign d_ext   = {{(OFF_W-DELAY_W){delay_q[DELAY_W-1]}}, delay_q};
  assign tol_ext = {{(OFF_W-TOL_W){1'b0}}, tol_q};

  always_comb begin
    case (off_sel)
      OFF_NEG_D:       alu_off = OFF_W'(0) - d_ext;
      OFF_D:           alu_off = d_ext;
      OFF_TOL_MINUS_D: alu_off = tol_ext - d_ext;
      default:         alu_off = tol_ext + d_ext;
    endcase
  end

  sots_alu u_alu (.a_i(alu_a), .b_i(alu_b), .off_i(alu_off), .neg_o(alu_neg));

  logic d_neg, slot_ok, push_req, push_full;
  logic [TIME_W-1:0] o_t, l_t;
  result_t rel;

  assign d_neg   = delay_q[DELAY_W-1];
  assign slot_ok = !out_vld_q || m_axis_tready;
  assign o_t     = o_rd[TIME_W-1:0];
  assign l_t     = l_rd[TIME_W-1:0];
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    rel.stat = SS_OK;
    rel.ltag = ltag_q;
    rel.rtag = rtag_q;
    rel.otag = o_rd[ENTRY_W-1:TIME_W];
    rel.ovld = 1'b1;
  end

  always_comb begin
    state_d = state_q;   phase_d = phase_q;   start_d = start_q;
    unsync_d = unsync_q; drop_d = drop_q;     dr_d = dr_q;
    fn_d = fn_q;         time_d = time_q;     tag_d = tag_q;
    ltag_d = ltag_q;     rtag_d = rtag_q;     n_d = n_q;
    stat_d = stat_q;     pend_d = pend_q;     pend_vld_d = pend_vld_q;
    out_d = out_q;       out_last_d = out_last_q; out_drop_d = out_drop_q;
    out_vld_d = (out_vld_q && !m_axis_tready);
    octl = '0; lctl = '0; rctl = '0;
    alu_a = start_q; alu_b = time_q; off_sel = OFF_D;
    push_req = 1'b0; push_full = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          fn_d   = func_e'(s_axis_tuser);
          time_d = s_axis_tdata[TIME_W-1:0];
          tag_d  = s_axis_tdata[TIME_W+TAG_W-1:TIME_W];
          if (func_e'(s_axis_tuser) == FN_SYNC) begin
            dr_d    = drop_q;
            drop_d  = 1'b0;
            state_d = ST_CHK;
          end else begin
            state_d = ST_ADD;
          end
        end
      end

      // start-up gating and push; compare is start - t + offset < 0
      ST_ADD: begin
        off_sel = d_neg ? OFF_NEG_D : OFF_D;
        if (fn_q == FN_ADD_ODOM) begin
          if (!d_neg) begin
            push_req = 1'b1;
            if (phase_q == PH_NOT_STARTED) begin
              start_d = time_q;
              phase_d = PH_STARTED;
            end
          end else if (phase_q == PH_STARTED) begin
            if (alu_neg) begin
              push_req = 1'b1;
              phase_d  = PH_NORMAL;
            end
          end else if (phase_q != PH_NOT_STARTED) begin
            push_req = 1'b1;
          end
          octl.push = push_req;
          push_full = o_full;
        end else begin
          if (!d_neg) begin
            if (phase_q == PH_STARTED) begin
              if (alu_neg) begin
                push_req = 1'b1;
                phase_d  = PH_NORMAL;
              end
            end else if (phase_q == PH_NORMAL) begin
              push_req = 1'b1;
            end
          end else if (phase_q == PH_NOT_STARTED) begin
            start_d = time_q;
            phase_d = PH_STARTED;
          end else begin
            push_req = 1'b1;
          end
          lctl.push = push_req && (fn_q == FN_ADD_LEFT);
          rctl.push = push_req && (fn_q == FN_ADD_RIGHT);
          push_full = (fn_q == FN_ADD_LEFT) ? l_full : r_full;
        end
        if (push_req && push_full) drop_d = 1'b1;
        state_d = ST_IDLE;
      end

      ST_CHK: begin
        if (phase_q != PH_NORMAL) begin
          stat_d  = SS_NOT_STARTED;
          state_d = ST_STAT;
        end else if (l_empty || r_empty || o_empty) begin
          stat_d  = SS_EMPTY;
          state_d = ST_STAT;
        end else begin
          lctl.rd_en = 1'b1; lctl.rd_back = 1'b1;
          octl.rd_en = 1'b1;
          rctl.rd_en = 1'b1;
          state_d = ST_GAP1;
        end
      end

      // newest left image too early for oldest odometry
      ST_GAP1: begin
        alu_a = l_t; alu_b = o_t; off_sel = OFF_TOL_MINUS_D;
        if (alu_neg) begin
          octl.clear = 1'b1; lctl.clear = 1'b1; rctl.clear = 1'b1;
          stat_d  = SS_GAP;
          state_d = ST_STAT;
        end else begin
          lctl.rd_en = 1'b1;
          octl.rd_en = 1'b1; octl.rd_back = 1'b1;
          state_d = ST_GAP2;
        end
      end

      // oldest left image too late for newest odometry
      ST_GAP2: begin
        alu_a = o_t; alu_b = l_t; off_sel = OFF_TOL_PLUS_D;
        if (alu_neg) begin
          octl.clear = 1'b1; lctl.clear = 1'b1; rctl.clear = 1'b1;
          stat_d  = SS_GAP;
          state_d = ST_STAT;
        end else begin
          state_d = ST_WAIT;
        end
      end

      ST_WAIT: begin
        alu_a = o_t; alu_b = l_t; off_sel = OFF_D;
        if ((8'(l_cnt) < 8'(iwc_q)) && (8'(o_cnt) < 8'(owc_q)) && alu_neg) begin
          stat_d  = SS_WAIT;
          state_d = ST_STAT;
        end else begin
          ltag_d = l_rd[ENTRY_W-1:TIME_W];
          rtag_d = r_rd[ENTRY_W-1:TIME_W];
          lctl.pop = 1'b1;
          rctl.pop = 1'b1;
          octl.rd_en = 1'b1;
          n_d = '0;
          state_d = ST_SCAN;
        end
      end

      // release odometry older than the delayed left image time
      ST_SCAN: begin
        alu_a = o_t; alu_b = l_t; off_sel = OFF_D;
        if (o_empty || (n_q == N_W'(MAX_RESULTS))) begin
          state_d = ST_FIN;
        end else if (alu_neg) begin
          if (!pend_vld_q || slot_ok) begin
            if (pend_vld_q) begin
              out_d      = pend_q;
              out_last_d = 1'b0;
              out_drop_d = dr_q;
              out_vld_d  = 1'b1;
            end
            pend_d     = rel;
            pend_vld_d = 1'b1;
            octl.pop   = 1'b1;
            n_d        = n_q + N_W'(1);
            unsync_d   = '0;
            state_d    = ST_NEXT;
          end
        end else if (unsync_q > ulim_q) begin
          unsync_d = '0;
          octl.clear = 1'b1; lctl.clear = 1'b1; rctl.clear = 1'b1;
          stat_d  = SS_UNSYNC;
          state_d = ST_STAT;
        end else begin
          if (unsync_q < UNSYNC_MAX) unsync_d = unsync_q + ULIM_W'(1);
          state_d = ST_FIN;
        end
      end

      ST_NEXT: begin
        octl.rd_en = 1'b1;
        state_d = ST_SCAN;
      end

      ST_FIN: begin
        if (slot_ok) begin
          if (pend_vld_q) begin
            out_d = pend_q;
          end else begin
            out_d.stat = SS_OK;
            out_d.ltag = ltag_q;
            out_d.rtag = rtag_q;
            out_d.otag = '0;
            out_d.ovld = 1'b0;
          end
          out_last_d = 1'b1;
          out_drop_d = dr_q;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      ST_STAT: begin
        if (slot_ok) begin
          out_d.stat = stat_q;
          out_d.ltag = '0;
          out_d.rtag = '0;
          out_d.otag = '0;
          out_d.ovld = 1'b0;
          out_last_d = 1'b1;
          out_drop_d = dr_q;
          out_vld_d  = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_NOT_STARTED;
      start_q    <= '0;
      unsync_q   <= '0;
      drop_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      start_q    <= start_d;
      unsync_q   <= unsync_d;
      drop_q     <= drop_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q       <= dr_d;
    fn_q       <= fn_d;
    time_q     <= time_d;
    tag_q      <= tag_d;
    ltag_q     <= ltag_d;
    rtag_q     <= rtag_d;
    n_q        <= n_d;
    stat_q     <= stat_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    out_drop_q <= out_drop_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_q.ovld, out_q.stat};
  assign m_axis_tdata  = {7'd0, out_drop_q, out_q.otag, out_q.rtag, out_q.ltag};

  `include "stereo_odom_timestamp_sync_assert.svh"

  `SOTS_ASSERT_NOW(a_pend_in_scan, pend_vld_q, (state_q == ST_SCAN || state_q == ST_NEXT || state_q == ST_FIN), "pending result outside release loop")
  `SOTS_ASSERT_NEXT(a_drop_cleared, (s_axis_tvalid && s_axis_tready && s_axis_tuser == FN_SYNC), !drop_q, "drop flag not cleared by sync request")
  `SOTS_ASSERT_NOW(a_status_no_odom, (m_axis_tvalid && out_q.stat != SS_OK), (!out_q.ovld && out_last_q), "status result carries odometry or is not last")
  `SOTS_ASSERT_NOW(a_not_started_empty, (phase_q == PH_NOT_STARTED), (o_empty && l_empty && r_empty), "queue filled before start")
  `SOTS_ASSERT_NOW(a_right_bounded, 1'b1, (r_cnt <= ICW'(IMAGE_DEPTH)), "right queue count beyond depth")

endmodule

FILE: rtl/sots_fifo.sv
// timestamped circular queue with one write port and one registered read port
// depends on sots_pkg
`timescale 1ns / 1ps
module sots_fifo import sots_pkg::*; #(
  parameter int unsigned DEPTH = IMAGE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fifo_ctl_t          ctl_i,
  input  logic [ENTRY_W-1:0] data_i,
  output logic [ENTRY_W-1:0] rd_data_o,
  output logic [CW-1:0]      count_o,
  output logic               empty_o,
  output logic               full_o
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic [AW-1:0]      head_q, head_d, tail, back, head_nx;
  logic [CW-1:0]      count_q, count_d;
  logic [CW:0]        sum, wrap;
  logic               push_ok, pop_ok;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign push_ok = ctl_i.push && !full_o;
  assign pop_ok  = ctl_i.pop && !empty_o;

  always_comb begin
    sum     = (CW+1)'(head_q) + (CW+1)'(count_q);
    wrap    = (sum >= (CW+1)'(DEPTH)) ? sum - (CW+1)'(DEPTH) : sum;
    tail    = wrap[AW-1:0];
    back    = (tail == '0) ? AW'(DEPTH - 1) : tail - AW'(1);
    head_nx = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctl_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else begin
      if (pop_ok) head_d = head_nx;
      count_d = count_q + CW'(push_ok) - CW'(pop_ok);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) mem[tail] <= data_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) rd_q <= mem[ctl_i.rd_back ? back : head_q];
  end

  assign rd_data_o = rd_q;
  assign count_o   = count_q;

endmodule

FILE: rtl/sots_alu.sv
// shared time compare unit: sign of (a - b + offset)
// depends on sots_pkg
`timescale 1ns / 1ps
module sots_alu import sots_pkg::*; (
  input  logic [TIME_W-1:0] a_i,
  input  logic [TIME_W-1:0] b_i,
  input  logic [OFF_W-1:0]  off_i,
  output logic              neg_o
);

  logic signed [ALU_W-1:0] res;

  always_comb begin
    res = $signed({2'b00, a_i}) - $signed({2'b00, b_i})
        + $signed({{(ALU_W-OFF_W){off_i[OFF_W-1]}}, off_i});
  end

  assign neg_o = res[ALU_W-1];

endmodule
